// ===== rtl/lruoc_pkg.sv =====
package lruoc_pkg;

    // Field widths fixed by the block's interface.
    localparam int ID_W      = 64;
    localparam int SLOT_W    = 4;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the identifier and clear the scan trackers
        logic scan;    // read one tag entry and advance the scan index
        logic commit;  // apply the update and present the result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // the scan index points at the last entry
    } ctrl_status_t;

endpackage

// ===== rtl/lruoc_ctrl.sv =====
module lruoc_ctrl
    import lruoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // Next state decode.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // State and the registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Commands follow directly from the state; load also needs start.
    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && start;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.commit = (state_reg == ST_COMMIT);
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/lruoc_datapath.sv =====
module lruoc_datapath
    import lruoc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic [ID_W-1:0]   file_id,
    input  ctrl_cmd_t         cmd,
    output ctrl_status_t      status,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              evicted,
    output logic [ID_W-1:0]   evicted_id
);

    localparam int IW = $clog2(ENTRIES);
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;

    // Tag memory, read one entry per cycle during the scan.
    logic [ID_W-1:0] tag_mem [ENTRIES];
    logic [ID_W-1:0] rd_data_reg;

    // Per-entry state.
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RW-1:0]      rank_reg  [ENTRIES];
    logic [RW-1:0]      rank_next [ENTRIES];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CAP_W-1:0]   cap_reg;

    // Scan control.
    logic [IW-1:0] scan_idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_valid_reg;
    logic [ID_W-1:0] id_reg;

    // Scan trackers.
    logic            found_reg;
    logic [IW-1:0]   match_idx_reg;
    logic [RW-1:0]   match_rank_reg;
    logic            free_found_reg;
    logic [IW-1:0]   free_idx_reg;
    logic            any_reg;
    logic [RW-1:0]   best_reg;
    logic [IW-1:0]   victim_idx_reg;
    logic [ID_W-1:0] victim_tag_reg;

    // Result registers.
    logic              done_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              evicted_reg;
    logic [ID_W-1:0]   evicted_id_reg;

    // Entry under evaluation.
    logic          cur_valid;
    logic [RW-1:0] cur_rank;
    logic          cur_match;

    // Commit decision.
    logic [MW-1:0] cap_ext;
    logic [MW-1:0] cap_eff;
    logic          have_free;
    logic          do_evict;
    logic [IW-1:0] new_slot;
    logic [ENTRIES-1:0] valid_kept;

    assign status.scan_last = (scan_idx_reg == IW'(ENTRIES - 1));

    assign cur_valid = valid_reg[rd_idx_reg];
    assign cur_rank  = rank_reg[rd_idx_reg];
    assign cur_match = cur_valid && (rd_data_reg == id_reg);

    // Capacity is clamped to the range one through ENTRIES.
    always_comb
    begin
        cap_ext = MW'(cap_reg);
        if (cap_ext == '0)
        begin
            cap_eff = MW'(1);
        end
        else if (cap_ext > MW'(ENTRIES))
        begin
            cap_eff = MW'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // Pick the slot for the identifier and decide on eviction.
    always_comb
    begin
        have_free = free_found_reg && (MW'(count_reg) < cap_eff);
        do_evict  = !found_reg && !have_free && any_reg;
        if (found_reg)
        begin
            new_slot = match_idx_reg;
        end
        else if (have_free)
        begin
            new_slot = free_idx_reg;
        end
        else if (any_reg)
        begin
            new_slot = victim_idx_reg;
        end
        else
        begin
            new_slot = '0;
        end
    end

    // Next valid bits, ranks and resident count for the commit.
    always_comb
    begin
        valid_kept = valid_reg;
        if (do_evict)
        begin
            valid_kept[victim_idx_reg] = 1'b0;
        end
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (found_reg)
            begin
                if (IW'(i) == new_slot)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < match_rank_reg))
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
            else
            begin
                if (IW'(i) == new_slot)
                begin
                    rank_next[i] = '0;
                end
                else if (valid_kept[i])
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
        end
        if (!found_reg)
        begin
            valid_next = valid_kept;
            valid_next[new_slot] = 1'b1;
            if (!do_evict)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    // Tag memory write on install and registered scan read.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !found_reg)
        begin
            tag_mem[new_slot] <= id_reg;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= tag_mem[scan_idx_reg];
        end
    end

    // Payload registers: identifier, tracker payloads and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= file_id;
        end
        if (rd_valid_reg)
        begin
            if (cur_match && !found_reg)
            begin
                match_idx_reg  <= rd_idx_reg;
                match_rank_reg <= cur_rank;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (cur_valid && (!any_reg || (cur_rank > best_reg)))
            begin
                best_reg       <= cur_rank;
                victim_idx_reg <= rd_idx_reg;
                victim_tag_reg <= rd_data_reg;
            end
        end
        if (cmd.commit)
        begin
            hit_reg        <= found_reg;
            slot_reg       <= SLOT_W'(new_slot);
            evicted_reg    <= do_evict;
            evicted_id_reg <= do_evict ? victim_tag_reg : '0;
        end
    end

    // Control state, per-entry state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_W'(CAP_RESET);
            valid_reg      <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            done_reg       <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            rd_valid_reg <= cmd.scan;
            rd_idx_reg   <= scan_idx_reg;
            done_reg     <= cmd.commit;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
            if (cmd.load)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                any_reg        <= 1'b0;
            end
            else if (rd_valid_reg)
            begin
                if (cur_match)
                begin
                    found_reg <= 1'b1;
                end
                if (!cur_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cur_valid)
                begin
                    any_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign slot       = slot_reg;
    assign evicted    = evicted_reg;
    assign evicted_id = evicted_id_reg;

endmodule

// ===== rtl/lru_object_cache_unit.sv =====
// Fully associative LRU cache of 64-bit identifiers. A request is taken when start is high
// and busy is low. Busy then stays high over scan, drain and commit; in that time one
// comparator walks the tag memory one entry per cycle, then the update is applied.
// The result is registered from the commit state. A new request can be taken in the
// cycle the result appears; the block takes no new request while one is in flight.
// The result is on hit, slot, evicted and evicted_id, which hold until the next commit,
// marked by done for exactly one cycle; the receiver cannot stall it, so it must capture
// the result in that cycle. Capacity is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, not enforced by the block. It takes effect
// on the next request. Valid bits are cleared at reset, so no clearing pass is needed.
module lru_object_cache_unit
    import lruoc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic              start,
    output logic              busy,
    input  logic [ID_W-1:0]   file_id,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              evicted,
    output logic [ID_W-1:0]   evicted_id
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Sequencer for the scan and commit.
    lruoc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Tag memory, recency ranks and result registers.
    lruoc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .file_id     (file_id),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .hit         (hit),
        .slot        (slot),
        .evicted     (evicted),
        .evicted_id  (evicted_id)
    );

    // A result appears only as a request finishes.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (!busy && $past(busy)))
        else $error("result strobe without a finishing request");

    // An accepted request holds the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A hit never evicts.
    assert property (@(posedge clk) disable iff (!rst_n) (done && hit) |-> !evicted)
        else $error("eviction reported on a hit");

    // The evicted identifier is zero when nothing was evicted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_id == '0))
        else $error("evicted identifier set without an eviction");

    // Commit is issued only once the scan has ended.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.commit |-> !cmd.scan && !cmd.load)
        else $error("commit overlaps scan or load");

endmodule

// ===== tb/tb_lru_object_cache_unit.sv =====
`timescale 1ns / 1ps

module tb_lru_object_cache_unit;
    import lruoc_pkg::*;

    localparam int NUM_ENTRIES   = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_LOOKUPS = 200;
    localparam int POOL_SIZE     = 24;

    // One lookup outcome as the block reports it.
    typedef struct {
        bit              hit;
        bit [SLOT_W-1:0] slot;
        bit              evicted;
        bit [ID_W-1:0]   evicted_id;
    } lookup_result_t;

    // Tracks the cache contents and recency order, and checks each reported lookup.
    class lru_lookup_scoreboard;
        bit [ID_W-1:0]  tags [NUM_ENTRIES];
        bit             valid [NUM_ENTRIES];
        int unsigned    rank [NUM_ENTRIES];
        int unsigned    resident;
        bit [CAP_W-1:0] capacity;
        lookup_result_t expected_lookups [$];
        int             errors;

        function new();
            foreach (valid[i])
            begin
                valid[i] = 1'b0;
                rank[i]  = 0;
                tags[i]  = '0;
            end
            resident = 0;
            capacity = CAP_W'(CAP_RESET);
            errors   = 0;
        endfunction

        function void set_capacity(bit [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // Applies one accepted lookup to the cache image and queues its outcome.
        function void note_lookup(bit [ID_W-1:0] id);
            lookup_result_t res;
            int unsigned    limit_cap;
            int unsigned    top_rank;
            bit             found;
            bit             have_free;
            bit             any;
            int             idx;
            int             i;

            res.hit        = 1'b0;
            res.slot       = '0;
            res.evicted    = 1'b0;
            res.evicted_id = '0;

            // A capacity of zero acts as one; anything above the entry count saturates.
            limit_cap = capacity;
            if (limit_cap < 1)
                limit_cap = 1;
            if (limit_cap > NUM_ENTRIES)
                limit_cap = NUM_ENTRIES;

            // The lowest matching valid entry wins.
            found = 1'b0;
            idx   = 0;
            for (i = 0; i < NUM_ENTRIES; i++)
            begin
                if (!found && valid[i] && tags[i] == id)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end

            if (found)
            begin
                // Entries more recent than the hit age by one; the hit becomes most recent.
                top_rank = rank[idx];
                for (i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (valid[i] && rank[i] < top_rank)
                        rank[i]++;
                end
                rank[idx] = 0;
            end
            else
            begin
                // Below capacity the lowest free entry is used.
                have_free = 1'b0;
                if (resident < limit_cap)
                begin
                    for (i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (!have_free && !valid[i])
                        begin
                            have_free = 1'b1;
                            idx       = i;
                        end
                    end
                end

                // Otherwise the oldest entry goes, the lowest index on a tie.
                if (!have_free)
                begin
                    any      = 1'b0;
                    top_rank = 0;
                    for (i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (valid[i] && (!any || rank[i] > top_rank))
                        begin
                            any      = 1'b1;
                            top_rank = rank[i];
                            idx      = i;
                        end
                    end
                    if (any)
                    begin
                        res.evicted    = 1'b1;
                        res.evicted_id = tags[idx];
                        valid[idx]     = 1'b0;
                        if (resident > 0)
                            resident--;
                    end
                    else
                        idx = 0;
                end

                // Every resident entry ages, then the new identifier is installed as newest.
                for (i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (valid[i])
                        rank[i]++;
                end
                tags[idx]  = id;
                valid[idx] = 1'b1;
                rank[idx]  = 0;
                if (resident < 31)
                    resident++;
            end

            res.hit  = found;
            res.slot = SLOT_W'(idx);
            expected_lookups.push_back(res);
        endfunction

        // Compares one reported lookup with the oldest outstanding expectation.
        function void check_lookup(logic got_hit, logic [SLOT_W-1:0] got_slot,
                                   logic got_evicted, logic [ID_W-1:0] got_evicted_id);
            lookup_result_t exp_res;

            if (expected_lookups.size() == 0)
            begin
                $error("unexpected lookup result: hit=%0b slot=%0d", got_hit, got_slot);
                errors++;
                return;
            end
            exp_res = expected_lookups.pop_front();
            if (got_hit !== exp_res.hit)
            begin
                $error("hit: expected %0b, got %0b", exp_res.hit, got_hit);
                errors++;
            end
            if (got_slot !== exp_res.slot)
            begin
                $error("slot: expected %0d, got %0d", exp_res.slot, got_slot);
                errors++;
            end
            if (got_evicted !== exp_res.evicted)
            begin
                $error("evicted: expected %0b, got %0b", exp_res.evicted, got_evicted);
                errors++;
            end
            if (got_evicted_id !== exp_res.evicted_id)
            begin
                $error("evicted_id: expected %h, got %h", exp_res.evicted_id, got_evicted_id);
                errors++;
            end
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    logic              start       = 1'b0;
    logic [ID_W-1:0]   file_id     = '0;
    logic              busy;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [ID_W-1:0]   evicted_id;

    lru_lookup_scoreboard lookups;
    bit                   gaps_on = 1'b1;
    int                   quiet_cycles = 0;
    bit [ID_W-1:0]        id_pool [POOL_SIZE];

    lru_object_cache_unit #(
        .ENTRIES (NUM_ENTRIES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .file_id     (file_id),
        .done        (done),
        .hit         (hit),
        .slot        (slot),
        .evicted     (evicted),
        .evicted_id  (evicted_id)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Samples both transaction types at the clock edge, checking results before noting requests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                lookups.check_lookup(hit, slot, evicted, evicted_id);
            if (start && !busy)
                lookups.note_lookup(file_id);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Ends a run that has stopped making progress.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_lru_object_cache_unit failed");
        $finish;
    end

    // Presents one identifier until it is taken, then maybe leaves a gap.
    task automatic issue_lookup(input bit [ID_W-1:0] id);
        start   <= 1'b1;
        file_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gaps_on && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    endtask

    // Waits until every accepted lookup has reported.
    task automatic wait_lookups_drained();
        start <= 1'b0;
        @(posedge clk);
        while (lookups.pending() != 0)
            @(posedge clk);
    endtask

    // Changes the capacity once the block has gone idle.
    task automatic write_capacity(input bit [CAP_W-1:0] value);
        wait_lookups_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        lookups.set_capacity(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        bit [CAP_W-1:0] phase_caps [7];
        bit [ID_W-1:0]  id;
        bit [ID_W-1:0]  last_id;
        int             pool_n;
        int             pick;

        lookups = new();
        foreach (id_pool[i])
            id_pool[i] = {$urandom, $urandom};
        phase_caps    = '{5, 9, 1, 12, 31, 16, 0};
        phase_caps[6] = CAP_W'($urandom_range(0, 31));
        last_id       = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: extreme identifiers, a hit, then a third entry.
        issue_lookup('0);
        issue_lookup({ID_W{1'b1}});
        issue_lookup('0);
        issue_lookup(64'h8000_0000_0000_0001);

        // Capacity zero behaves as one, so a miss evicts the oldest entry.
        write_capacity(0);
        issue_lookup(64'h0123_4567_89ab_cdef);
        issue_lookup(64'h0123_4567_89ab_cdef);

        // A lowered capacity evicts on every miss without shrinking the resident count.
        write_capacity(2);
        issue_lookup(64'hfedc_ba98_7654_3210);
        issue_lookup('0);

        // A capacity past the entry count saturates; the cache grows again.
        write_capacity(17);
        for (int k = 0; k < 5; k++)
            issue_lookup(64'h100 + k);
        issue_lookup(64'h8000_0000_0000_0001);
        issue_lookup(64'h0123_4567_89ab_cdef);

        // Random phases over a working set, with a phase that never pauses.
        for (int phase = 0; phase < 7; phase++)
        begin
            write_capacity(phase_caps[phase]);
            gaps_on = (phase != 3);
            pool_n  = $urandom_range(4, POOL_SIZE);
            repeat (PHASE_LOOKUPS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    id = {$urandom, $urandom};
                else if (pick < 18)
                    id = last_id;
                else
                    id = id_pool[$urandom_range(0, pool_n - 1)];
                last_id = id;
                issue_lookup(id);
            end
        end

        wait_lookups_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (lookups.errors == 0 && lookups.pending() == 0)
            $display("tb_lru_object_cache_unit passed");
        else
            $display("tb_lru_object_cache_unit failed");
        $finish;
    end

endmodule

// ===== lru_object_cache_unit.f =====
rtl/lruoc_pkg.sv
rtl/lruoc_ctrl.sv
rtl/lruoc_datapath.sv
rtl/lru_object_cache_unit.sv
tb/tb_lru_object_cache_unit.sv
